### src/brr_pkg.sv
// Shared constants and types for the block reverse reorder unit.
package brr_pkg;

    localparam int MAX_GROUP_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int GROUP_SIZE_W  = 5;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST = GROUP_SIZE_W'(1);

    // register index, taken from paddr[2]
    localparam logic REG_GROUP_SIZE = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } brr_state_t;

endpackage

### src/brr_regs.sv
// APB configuration register file for the block reverse reorder unit.
module brr_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [brr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [brr_pkg::GROUP_SIZE_W-1:0] group_size
);
    import brr_pkg::*;

    logic [GROUP_SIZE_W-1:0] group_size_reg;
    logic [GROUP_SIZE_W-1:0] group_size_next;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        group_size_next = group_size_reg;
        if (wr_en && (paddr[2] == REG_GROUP_SIZE))
        begin
            group_size_next = pwdata[GROUP_SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RST;
        end
        else
        begin
            group_size_reg <= group_size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_GROUP_SIZE)
        begin
            prdata = APB_DATA_W'(group_size_reg);
        end
    end

    assign group_size = group_size_reg;

endmodule

### src/block_reverse_reorder_unit.sv
// Top level of the block reverse reorder unit: group buffer and emit sequencer.
//
// Input stream s_*: one 32-bit value per transfer, s_tlast marks the final
// value of a list. Values collect in a MAX_GROUP-entry buffer memory. When
// group_size values are held the group leaves reversed on m_*; when a list
// ends on a partial group, that group leaves in arrival order.
// m_tlast marks the last value of each emitted run, m_tuser the last value of
// the list. group_size (APB register 0) is clamped to 1..MAX_GROUP.
// Flow: a transfer that does not close a group keeps s_tready high. A closing
// transfer starts a run of n values that are read from the buffer memory one
// per cycle while m_tready does not stall; s_tready stays low until the last
// read of the run has been handed to the output register.
// The first value of a run passes through the memory read register and then
// the output register.
// A stalled m_tready holds the output register and one read in flight; reads
// stop until it drains. Reset empties the buffer count and sets group_size 1;
// buffer contents are not cleared and no clearing pass is needed.
module block_reverse_reorder_unit
#(
    parameter int MAX_GROUP = brr_pkg::MAX_GROUP_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [brr_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value
    input  logic                           s_tlast,   // list_end
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brr_pkg::DATA_W-1:0]     m_tdata,   // [31:0] out_value
    output logic                           m_tlast,   // run_last
    output logic                           m_tuser,   // [0] out_list_end
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [brr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [brr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [brr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import brr_pkg::*;

    localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int CMP_W  = (CNT_W > GROUP_SIZE_W) ? CNT_W : GROUP_SIZE_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_GROUP);
    localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1);

    logic [GROUP_SIZE_W-1:0] group_size;

    brr_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .group_size (group_size)
    );

    // control state
    brr_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rev_reg, rev_next;
    logic              end_reg, end_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;
    logic              rd_end_reg, rd_end_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [DATA_W-1:0] mem [MAX_GROUP];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_end_reg;

    logic              in_xfer;
    logic              wr_en;
    logic              rd_en;
    logic              load;
    logic [CMP_W-1:0]  gs_cmp;
    logic [CMP_W-1:0]  k_cmp;
    logic [CMP_W-1:0]  n_cmp;
    logic [CNT_W-1:0]  n_cnt;
    logic              full;

    // effective group size: 0 acts as 1, clamp to MAX_GROUP
    always_comb
    begin
        gs_cmp = CMP_W'(group_size);
        if (gs_cmp == '0)
        begin
            k_cmp = ONE_CMP;
        end
        else if (gs_cmp > MAX_CMP)
        begin
            k_cmp = MAX_CMP;
        end
        else
        begin
            k_cmp = gs_cmp;
        end
    end

    assign n_cnt  = fill_reg + CNT_W'(1);
    assign n_cmp  = CMP_W'(n_cnt);
    assign full   = (n_cmp >= k_cmp);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign wr_en    = in_xfer;

    // a pending read moves into the output register when it is free
    assign load  = rd_pend_reg && (!out_valid_reg || m_tready);
    assign rd_en = (state_reg == ST_EMIT) && (remain_reg != '0) && (!rd_pend_reg || load);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        remain_next    = remain_reg;
        addr_next      = addr_reg;
        rev_next       = rev_reg;
        end_next       = end_reg;
        rd_pend_next   = rd_pend_reg;
        rd_last_next   = rd_last_reg;
        rd_end_next    = rd_end_reg;
        out_valid_next = out_valid_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            rd_pend_next   = 1'b0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (full || s_tlast)
                    begin
                        state_next  = ST_EMIT;
                        fill_next   = '0;
                        remain_next = n_cnt;
                        rev_next    = full;
                        end_next    = s_tlast;
                        addr_next   = full ? fill_reg[ADDR_W-1:0] : '0;
                    end
                    else
                    begin
                        fill_next = n_cnt;
                    end
                end
            end
            ST_EMIT:
            begin
                if (rd_en)
                begin
                    remain_next  = remain_reg - CNT_W'(1);
                    addr_next    = rev_reg ? (addr_reg - ADDR_W'(1)) : (addr_reg + ADDR_W'(1));
                    rd_pend_next = 1'b1;
                    rd_last_next = (remain_reg == CNT_W'(1));
                    rd_end_next  = (remain_reg == CNT_W'(1)) && end_reg;
                end
                else if ((remain_reg == '0) && (!rd_pend_reg || load))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            remain_reg    <= '0;
            addr_reg      <= '0;
            rev_reg       <= 1'b0;
            end_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            rd_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            addr_reg      <= addr_next;
            rev_reg       <= rev_next;
            end_reg       <= end_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            rd_end_reg    <= rd_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // group buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
            out_end_reg  <= rd_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for block_reverse_reorder_unit: list streams, group reversal, APB setup.
module testbench;
    import brr_pkg::*;

    localparam int GRP_MAX      = MAX_GROUP_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SEG_ITEMS    = 30;
    localparam int MAX_REPORTS  = 10;

    localparam logic [APB_ADDR_W-1:0] ADDR_GROUP_SIZE = {REG_GROUP_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_GROUP_SIZE, 2'b00};

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              list_end;
    } elem_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              run_last;
        logic              list_end;
    } reordered_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;   // [31:0] value
    logic                  s_tlast  = 1'b0; // list_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;         // [31:0] out_value
    logic                  m_tlast;         // run_last
    logic                  m_tuser;         // [0] out_list_end
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    elem_t       list_q[$];       // elements waiting to be sent
    reordered_t  reordered_q[$];  // predicted output order
    elem_t       drv_elem;

    // predictor state
    logic [DATA_W-1:0]       held_vals [GRP_MAX];
    int unsigned             held_cnt = 0;
    logic [GROUP_SIZE_W-1:0] grp_reg  = GROUP_SIZE_RST;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned bad_count = 0;
    int unsigned cycles    = 0;

    block_reverse_reorder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(input logic [GROUP_SIZE_W-1:0] sz);
        if (sz == 0)
            return 1;
        if (sz > GRP_MAX)
            return GRP_MAX;
        return sz;
    endfunction

    // stores one element, emits the group when full or when the list ends
    task automatic predict_runs(input elem_t e);
        int unsigned k;
        int unsigned n;
        int unsigned i;
        reordered_t  r;
        k = clamp_size(grp_reg);
        if (held_cnt < GRP_MAX)
        begin
            held_vals[held_cnt] = e.value;
            held_cnt++;
        end
        n = held_cnt;
        if (n >= k)
        begin
            for (i = 0; i < n; i++)
            begin
                r.value    = held_vals[n - 1 - i];
                r.run_last = (i == n - 1);
                r.list_end = (i == n - 1) && e.list_end;
                reordered_q.push_back(r);
            end
            held_cnt = 0;
        end
        else if (e.list_end)
        begin
            // partial group at list end keeps arrival order
            for (i = 0; i < n; i++)
            begin
                r.value    = held_vals[i];
                r.run_last = (i == n - 1);
                r.list_end = (i == n - 1);
                reordered_q.push_back(r);
            end
            held_cnt = 0;
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (list_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                drv_elem = list_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_elem.value;
                s_tlast  <= drv_elem.list_end;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // register shadow, prediction and output check share one block to keep ordering fixed
    always @(posedge clk)
    begin
        reordered_t got;
        reordered_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_GROUP_SIZE)
                grp_reg = pwdata[GROUP_SIZE_W-1:0];
            if (s_tvalid && s_tready)
                predict_runs('{value: s_tdata, list_end: s_tlast});
            if (m_tvalid && m_tready)
            begin
                got = '{value: m_tdata, run_last: m_tlast, list_end: m_tuser};
                if (reordered_q.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("unexpected transfer: value %h last %b end %b",
                                 got.value, got.run_last, got.list_end);
                end
                else
                begin
                    want = reordered_q.pop_front();
                    if (got.value !== want.value || got.run_last !== want.run_last ||
                        got.list_end !== want.list_end)
                    begin
                        bad_count++;
                        if (bad_count <= MAX_REPORTS)
                            $display("mismatch: value %h/%h last %b/%b end %b/%b (exp/act)",
                                     want.value, got.value, want.run_last, got.run_last,
                                     want.list_end, got.list_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_elem(input logic [DATA_W-1:0] value, input logic list_end);
        list_q.push_back('{value: value, list_end: list_end});
    endtask

    // all sent, all results seen, then let a held element settle
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (list_q.size() != 0 || s_tvalid || reordered_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [GROUP_SIZE_W-1:0] sz;
        int unsigned             k;
        int unsigned             len;
        int unsigned             cnt;
        int unsigned             j;
        bit                      broken;

        send_idle = 30;
        recv_idle = 66;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset size of 1: pass-through
        push_elem(32'h8000_0000, 1'b0);
        push_elem(32'h7FFF_FFFF, 1'b1);
        wait_quiet();

        // zero acts as one
        apb_write(ADDR_GROUP_SIZE, 32'd0);
        push_elem(32'h0000_0000, 1'b1);
        wait_quiet();

        // full group that also ends the list, then a partial group
        apb_write(ADDR_GROUP_SIZE, 32'd3);
        push_elem(32'd1, 1'b0);
        push_elem(32'd2, 1'b0);
        push_elem(32'd3, 1'b1);
        push_elem(32'd4, 1'b0);
        push_elem(32'd5, 1'b1);
        wait_quiet();

        // unmapped write must leave size at 3
        apb_write(ADDR_UNMAPPED, 32'd1);
        push_elem(32'd6, 1'b0);
        push_elem(32'd7, 1'b0);
        wait_quiet();

        // size lowered below the fill: next element flushes all three reversed
        apb_write(ADDR_GROUP_SIZE, 32'd1);
        push_elem(32'd8, 1'b0);
        push_elem(32'hFFFF_FFFF, 1'b1);
        wait_quiet();

        // oversize clamps to the buffer depth; upper pwdata bits ignored
        apb_write(ADDR_GROUP_SIZE, 32'hFFFF_FFF4);
        push_elem(32'hA5A5_A5A5, 1'b0);
        push_elem(32'h5A5A_5A5A, 1'b0);
        push_elem(32'h0000_0001, 1'b1);
        wait_quiet();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle = 30;
                    recv_idle = 66;
                end
                1:
                begin
                    send_idle = 66;
                    recv_idle = 30;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (seg)
                0:       sz = 5'd16;
                1:       sz = 5'd1;
                2:       sz = 5'd31;
                3:       sz = 5'd0;
                default: sz = GROUP_SIZE_W'($urandom_range(2, 15));
            endcase
            apb_write(ADDR_GROUP_SIZE, {27'd0, sz});
            k   = clamp_size(sz);
            cnt = 0;
            while (cnt < SEG_ITEMS)
            begin
                len    = $urandom_range(1, 2 * k + 2);
                // an unterminated list runs into the next one, or across a size change
                broken = ($urandom_range(9) == 0);
                for (j = 0; j < len; j++)
                begin
                    push_elem(pick_value(), (j == len - 1) && !broken);
                    cnt++;
                end
            end
            wait_quiet();
        end

        if (bad_count == 0 && reordered_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
